[rtl/core/greedy_room_allocator_macros.svh]
// Assertion helpers for the room allocator.
// Each macro takes a label, the clock, the active-low reset, a trigger and a check.
`ifndef GREEDY_ROOM_ALLOCATOR_MACROS_SVH
`define GREEDY_ROOM_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define GRM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("allocator check failed");
`define GRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("allocator check failed");
`else
`define GRM_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GRM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/grm_pkg.sv]
`default_nettype none
package grm_pkg;
    localparam int MAX_ROOMS_DEF = 128;
    localparam int TIME_BITS_DEF = 48;
    localparam int IN_TIME_W     = 40;
    localparam int OUT_TIME_W    = 48;
    localparam int ROOM_OUT_W    = 7;
    localparam int USE_W         = 24;
    localparam int RC_W          = 8;
    localparam logic [RC_W-1:0]  RC_RESET = 8'd128;
    localparam logic [USE_W-1:0] USE_MAX  = {USE_W{1'b1}};
endpackage
`default_nettype wire

[rtl/core/grm_ram.sv]
`default_nettype none
module grm_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[rtl/core/greedy_room_allocator.sv]
`default_nettype none
`include "greedy_room_allocator_macros.svh"
// Greedy room allocator. Each booking word (start, end, last flag) is taken when
// start is high and busy is low. The block scans the active rooms one per cycle
// through a single read port of the room memory, keeping the first free room
// (stored end at or before the start) and, in the same pass, the room with the
// earliest end. With n active rooms a word passes from acceptance to the next
// possible acceptance through up to n reads, a compare of the last word read,
// the write-back, and the result strobe; a free room found early ends the scan
// at once. The result on the o_ ports is marked by o_valid for exactly one
// cycle, and the receiver cannot stall it, so sample it then.
// After reset and after every word flagged last_meeting the room memory is
// cleared in a pass over all MAX_ROOMS rooms during which busy stays high;
// room_count writes are still taken then. Write room_count only while idle.
module greedy_room_allocator
    import grm_pkg::*;
#(
    parameter int MAX_ROOMS = MAX_ROOMS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [IN_TIME_W-1:0]  i_start_time,
    input  wire logic [IN_TIME_W-1:0]  i_end_time,
    input  wire logic                  i_last_meeting,
    input  wire logic                  i_cfg_we,
    input  wire logic [RC_W-1:0]       i_cfg_wdata,
    output logic                       o_valid,
    output logic [ROOM_OUT_W-1:0]      o_room,
    output logic [OUT_TIME_W-1:0]      o_begin_time,
    output logic [OUT_TIME_W-1:0]      o_finish_time,
    output logic                       o_was_delayed,
    output logic [ROOM_OUT_W-1:0]      o_busiest_room,
    output logic [USE_W-1:0]           o_busiest_count,
    output logic                       o_batch_done
);
    localparam int ROOM_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
    localparam int NW     = (ROOM_W + 1 > RC_W) ? ROOM_W + 1 : RC_W;
    localparam int SUM_W  = ((TIME_BITS > IN_TIME_W) ? TIME_BITS : IN_TIME_W) + 1;
    localparam int WORD_W = TIME_BITS + USE_W;
    localparam logic [ROOM_W-1:0]    LAST_ADDR = ROOM_W'(MAX_ROOMS - 1);
    localparam logic [SUM_W-1:0]     TMAX_EXT  = SUM_W'({TIME_BITS{1'b1}});
    localparam logic [NW-1:0]        MAX_EXT   = NW'(MAX_ROOMS);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLEAR = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_WRITE = 2'd3;

    // Sequencer and scan state
    logic [1:0]           r_state, n_state;
    logic [ROOM_W-1:0]    r_addr, n_addr;
    logic                 r_issue, n_issue;
    logic                 r_dv, n_dv;
    logic [ROOM_W-1:0]    r_di, n_di;
    logic [ROOM_W-1:0]    r_last_idx, n_last_idx;
    logic [RC_W-1:0]      r_room_count;

    // Current booking and chosen room
    logic [TIME_BITS-1:0] r_start, n_start;
    logic [IN_TIME_W-1:0] r_dur, n_dur;
    logic                 r_last, n_last;
    logic [ROOM_W-1:0]    r_pick_idx, n_pick_idx;
    logic [TIME_BITS-1:0] r_pick_end, n_pick_end;
    logic [USE_W-1:0]     r_pick_uses, n_pick_uses;
    logic                 r_found, n_found;

    // Busiest-room tracker
    logic [ROOM_W-1:0]    r_best_room, n_best_room;
    logic [USE_W-1:0]     r_best_uses, n_best_uses;

    // Result word
    logic                 r_valid, n_valid;
    logic [ROOM_W-1:0]    r_res_room, n_res_room;
    logic [TIME_BITS-1:0] r_res_begin, n_res_begin;
    logic [TIME_BITS-1:0] r_res_finish, n_res_finish;
    logic                 r_res_delayed, n_res_delayed;
    logic [ROOM_W-1:0]    r_res_best_room, n_res_best_room;
    logic [USE_W-1:0]     r_res_best_uses, n_res_best_uses;
    logic                 r_res_done, n_res_done;

    // Memory port
    logic                 ram_we, ram_re;
    logic [ROOM_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata, ram_rdata;
    logic [TIME_BITS-1:0] rd_end;
    logic [USE_W-1:0]     rd_uses;

    // Shared datapath
    logic                 accept;
    logic [NW-1:0]        rc_ext, n_active;
    logic [SUM_W-1:0]     start_ext;
    logic [TIME_BITS-1:0] w_begin, w_finish;
    logic [SUM_W-1:0]     w_sum;
    logic [USE_W-1:0]     w_uses;
    logic                 w_take_best;

    grm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ROOMS)
    ) u_room_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_end  = ram_rdata[USE_W +: TIME_BITS];
    assign rd_uses = ram_rdata[USE_W-1:0];
    assign accept  = start && !busy;

    // Active room count: zero means one room, clip at the memory depth
    assign rc_ext   = NW'(r_room_count);
    assign n_active = (r_room_count == '0) ? NW'(1) : ((rc_ext > MAX_EXT) ? MAX_EXT : rc_ext);

    // Saturate the requested start into the time range
    assign start_ext = SUM_W'(i_start_time);

    // Write-back arithmetic: shift the meeting if delayed, saturate the end and the count
    assign w_begin     = r_found ? r_start : r_pick_end;
    assign w_sum       = SUM_W'(w_begin) + SUM_W'(r_dur);
    assign w_finish    = (w_sum > TMAX_EXT) ? {TIME_BITS{1'b1}} : TIME_BITS'(w_sum);
    assign w_uses      = (r_pick_uses == USE_MAX) ? r_pick_uses : r_pick_uses + 1'b1;
    assign w_take_best = (w_uses > r_best_uses) ||
                         ((w_uses == r_best_uses) && (r_pick_idx < r_best_room));

    always_comb begin
        n_state         = r_state;
        n_addr          = r_addr;
        n_issue         = r_issue;
        n_dv            = 1'b0;
        n_di            = r_di;
        n_last_idx      = r_last_idx;
        n_start         = r_start;
        n_dur           = r_dur;
        n_last          = r_last;
        n_pick_idx      = r_pick_idx;
        n_pick_end      = r_pick_end;
        n_pick_uses     = r_pick_uses;
        n_found         = r_found;
        n_best_room     = r_best_room;
        n_best_uses     = r_best_uses;
        n_valid         = 1'b0;
        n_res_room      = r_res_room;
        n_res_begin     = r_res_begin;
        n_res_finish    = r_res_finish;
        n_res_delayed   = r_res_delayed;
        n_res_best_room = r_res_best_room;
        n_res_best_uses = r_res_best_uses;
        n_res_done      = r_res_done;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_waddr       = r_pick_idx;
        ram_wdata       = '0;

        case (r_state)
            ST_CLEAR: begin
                // Zero one room per cycle
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = '0;
                if (r_addr == LAST_ADDR) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_start    = (start_ext > TMAX_EXT) ? {TIME_BITS{1'b1}}
                                                        : TIME_BITS'(i_start_time);
                    n_dur      = (i_end_time > i_start_time) ? i_end_time - i_start_time
                                                             : '0;
                    n_last     = i_last_meeting;
                    n_last_idx = ROOM_W'(n_active - 1'b1);
                    n_addr     = '0;
                    n_issue    = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue one read a cycle; compare the word that returns
                if (r_issue) begin
                    ram_re = 1'b1;
                    n_dv   = 1'b1;
                    n_di   = r_addr;
                    if (r_addr == r_last_idx) begin
                        n_issue = 1'b0;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
                if (r_dv) begin
                    if (rd_end <= r_start) begin
                        n_pick_idx  = r_di;
                        n_pick_end  = rd_end;
                        n_pick_uses = rd_uses;
                        n_found     = 1'b1;
                        n_issue     = 1'b0;
                        n_dv        = 1'b0;
                        n_state     = ST_WRITE;
                    end else begin
                        if ((r_di == '0) || (rd_end < r_pick_end)) begin
                            n_pick_idx  = r_di;
                            n_pick_end  = rd_end;
                            n_pick_uses = rd_uses;
                        end
                        if (r_di == r_last_idx) begin
                            n_found = 1'b0;
                            n_dv    = 1'b0;
                            n_state = ST_WRITE;
                        end
                    end
                end
            end
            ST_WRITE: begin
                // Store the new end and count, then present the result word
                ram_we          = 1'b1;
                ram_waddr       = r_pick_idx;
                ram_wdata       = {w_finish, w_uses};
                n_valid         = 1'b1;
                n_res_room      = r_pick_idx;
                n_res_begin     = w_begin;
                n_res_finish    = w_finish;
                n_res_delayed   = !r_found;
                n_res_best_room = w_take_best ? r_pick_idx : r_best_room;
                n_res_best_uses = w_take_best ? w_uses : r_best_uses;
                n_res_done      = r_last;
                if (r_last) begin
                    n_best_room = '0;
                    n_best_uses = '0;
                    n_addr      = '0;
                    n_state     = ST_CLEAR;
                end else begin
                    n_best_room = n_res_best_room;
                    n_best_uses = n_res_best_uses;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_addr       <= '0;
            r_issue      <= 1'b0;
            r_dv         <= 1'b0;
            r_room_count <= RC_RESET;
            r_best_room  <= '0;
            r_best_uses  <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue     <= n_issue;
            r_dv        <= n_dv;
            r_best_room <= n_best_room;
            r_best_uses <= n_best_uses;
            r_valid     <= n_valid;
            if (i_cfg_we) begin
                r_room_count <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_di            <= n_di;
        r_last_idx      <= n_last_idx;
        r_start         <= n_start;
        r_dur           <= n_dur;
        r_last          <= n_last;
        r_pick_idx      <= n_pick_idx;
        r_pick_end      <= n_pick_end;
        r_pick_uses     <= n_pick_uses;
        r_found         <= n_found;
        r_res_room      <= n_res_room;
        r_res_begin     <= n_res_begin;
        r_res_finish    <= n_res_finish;
        r_res_delayed   <= n_res_delayed;
        r_res_best_room <= n_res_best_room;
        r_res_best_uses <= n_res_best_uses;
        r_res_done      <= n_res_done;
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_valid         = r_valid;
    assign o_room          = ROOM_OUT_W'(r_res_room);
    assign o_begin_time    = OUT_TIME_W'(r_res_begin);
    assign o_finish_time   = OUT_TIME_W'(r_res_finish);
    assign o_was_delayed   = r_res_delayed;
    assign o_busiest_room  = ROOM_OUT_W'(r_res_best_room);
    assign o_busiest_count = r_res_best_uses;
    assign o_batch_done    = r_res_done;

    // A taken word blocks further words and produces no result next cycle
    `GRM_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy && !o_valid)
    // The chosen room always lies inside the active range
    `GRM_ASSERT_SAME(a_pick_range, i_clk, i_rst_n, r_state == ST_WRITE, r_pick_idx <= r_last_idx)
    // A meeting never ends before it begins
    `GRM_ASSERT_SAME(a_finish_order, i_clk, i_rst_n, r_state == ST_WRITE, w_finish >= w_begin)
    // The busiest room has at least the meeting just placed
    `GRM_ASSERT_SAME(a_best_nonzero, i_clk, i_rst_n, o_valid, o_busiest_count != '0)
    // Closing a batch starts the clearing pass
    `GRM_ASSERT_NEXT(a_batch_clear, i_clk, i_rst_n, o_valid && o_batch_done, busy)
endmodule
`default_nettype wire
